### rtl/sgs_pkg.sv
`default_nettype none

package sgs_pkg;

    // Field and datapath widths
    localparam int PIX_W      = 12;
    localparam int STEP_W     = 16;
    localparam int TOL_W      = 8;
    localparam int ANG_W      = 20;
    localparam int RAD_W      = 20;
    localparam int OUT_W      = 21;
    localparam int ERR_W      = 15;
    localparam int Z_W        = 21;
    localparam int XY_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier: signed A by Q30 B, product taken down by 30
    localparam int MUL_A_W     = 23;
    localparam int MUL_SPLIT   = 16;
    localparam int MUL_PP_W    = MUL_A_W + MUL_SPLIT + 1;
    localparam int MUL_P_W     = MUL_A_W + XY_W;
    localparam int MUL_SHIFT   = 30;
    localparam int MUL_R_W     = MUL_P_W - MUL_SHIFT;

    // Arctangent table
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_LEN);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_HALF_TOL     = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } cfg_reg_t;

    // Configuration reset values
    localparam logic [STEP_W-1:0] STEP_SIZE_RST    = 16'd655;
    localparam logic [TOL_W-1:0]  HALF_TOL_RST     = 8'd1;
    localparam logic [PIX_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [PIX_W-1:0]  IMAGE_HEIGHT_RST = 12'd480;

    // Gaze state reset values and limits (Q16)
    localparam logic signed [ANG_W-1:0] ANGLE_RST  = 20'sd102943;
    localparam logic [RAD_W-1:0]        RADIUS_RST = 20'd52429;
    localparam logic signed [ANG_W-1:0] ANG_MAX    = 20'sd524287;
    localparam logic signed [ANG_W-1:0] ANG_MIN    = -20'sd524288;
    localparam logic [RAD_W-1:0]        RAD_MAX    = 20'd1048575;
    localparam logic signed [OUT_W-1:0] OUT_MAX    = 21'sd1048575;
    localparam logic signed [OUT_W-1:0] OUT_MIN    = -21'sd1048576;

    // Angle range reduction constants (Q16)
    localparam logic signed [Z_W-1:0] PI_Q16          = 21'sd205887;
    localparam logic signed [Z_W-1:0] NEG_PI_Q16      = -21'sd205887;
    localparam logic signed [Z_W-1:0] TWO_PI_Q16      = 21'sd411775;
    localparam logic signed [Z_W-1:0] HALF_PI_Q16     = 21'sd102944;
    localparam logic signed [Z_W-1:0] NEG_HALF_PI_Q16 = -21'sd102944;

    // CORDIC start vector, gain already folded in (Q30)
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Sine and cosine pair, Q30
    typedef struct packed {
        logic signed [XY_W-1:0] sin_q30;
        logic signed [XY_W-1:0] cos_q30;
    } trig_t;

    // Rounded arctangent of 2^-i in Q16, zero past the seventeenth entry
    function automatic logic [15:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/stereo_gaze_servo_step.sv
// Stereo gaze servo, one tick per input beat.
// Input channel (in_valid/in_ready) carries the start bit, both visibility
// flags and both blob centroids. Output channel (out_valid/out_ready) carries
// the Cartesian fixation point and the still_active and stepped flags; every
// input beat gives exactly one output beat. The configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and should be
// written only while no tick is in flight.
// An active tick first runs the error and update stages; an inactive tick
// skips them. Then the single CORDIC unit runs polar then azimuth, one
// rotation per cycle, followed by four passes through the shared
// multiplier, each adding a low and a high partial product.
// in_ready is high only while the block waits for a tick, so one tick is in
// flight at a time, and the next is taken once its result is registered.
// The finished beat sits in an output register: the next tick is taken while
// it waits, and a new result is held back until the receiver has drained the
// previous one.
// Reset clears the output register and returns the gaze to polar and azimuth
// pi/2, radius 0.8 m, servo inactive, with default register values.
`default_nettype none

module stereo_gaze_servo_step #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // Tick input
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic                                    start_req,
    input  wire logic                                    left_visible,
    input  wire logic [sgs_pkg::PIX_W-1:0]               left_x,
    input  wire logic [sgs_pkg::PIX_W-1:0]               left_y,
    input  wire logic                                    right_visible,
    input  wire logic [sgs_pkg::PIX_W-1:0]               right_x,
    input  wire logic [sgs_pkg::PIX_W-1:0]               right_y,
    // Result output
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic signed [sgs_pkg::OUT_W-1:0]             fixation_x,
    output logic signed [sgs_pkg::OUT_W-1:0]             fixation_y,
    output logic signed [sgs_pkg::OUT_W-1:0]             fixation_z,
    output logic                                         still_active,
    output logic                                         stepped,
    // Configuration writes
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [sgs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [sgs_pkg::CFG_DATA_W-1:0]          cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_UPD,
        S_CPOL,
        S_WPOL,
        S_CAZ,
        S_WAZ,
        S_M_T,
        S_W_T,
        S_M_Y,
        S_W_Y,
        S_M_X,
        S_W_X,
        S_M_Z,
        S_W_Z,
        S_FIN
    } seq_state_t;

    localparam int ERR_W = sgs_pkg::ERR_W;

    // Configuration registers
    logic [sgs_pkg::STEP_W-1:0]             step_size_reg;
    logic [sgs_pkg::TOL_W-1:0]              half_tol_reg;
    logic [sgs_pkg::PIX_W-1:0]              width_reg;
    logic [sgs_pkg::PIX_W-1:0]              height_reg;

    // Gaze state
    seq_state_t                             state_reg;
    logic signed [sgs_pkg::ANG_W-1:0]       polar_reg;
    logic signed [sgs_pkg::ANG_W-1:0]       azim_reg;
    logic [sgs_pkg::RAD_W-1:0]              radius_reg;
    logic                                   active_reg;
    logic                                   stepped_reg;

    // Captured tick
    logic                                   both_vis_reg;
    logic [sgs_pkg::PIX_W-1:0]              lx_reg;
    logic [sgs_pkg::PIX_W-1:0]              ly_reg;
    logic [sgs_pkg::PIX_W-1:0]              rx_reg;
    logic [sgs_pkg::PIX_W-1:0]              ry_reg;

    // Step decisions
    logic                                   pol_move_reg;
    logic                                   pol_up_reg;
    logic                                   az_move_reg;
    logic                                   az_up_reg;
    logic                                   rad_move_reg;
    logic                                   rad_up_reg;
    logic                                   all_centred_reg;

    // Trig and product intermediates
    sgs_pkg::trig_t                         pol_trig_reg;
    sgs_pkg::trig_t                         az_trig_reg;
    logic signed [sgs_pkg::MUL_A_W-1:0]     t_reg;
    logic signed [sgs_pkg::OUT_W-1:0]       fx_reg;
    logic signed [sgs_pkg::OUT_W-1:0]       fy_reg;
    logic signed [sgs_pkg::OUT_W-1:0]       fz_reg;

    // Output register
    logic                                   out_valid_reg;
    logic signed [sgs_pkg::OUT_W-1:0]       fixation_x_reg;
    logic signed [sgs_pkg::OUT_W-1:0]       fixation_y_reg;
    logic signed [sgs_pkg::OUT_W-1:0]       fixation_z_reg;
    logic                                   still_active_reg;
    logic                                   stepped_out_reg;

    // Combinational
    logic [sgs_pkg::PIX_W:0]                y_sum;
    logic signed [ERR_W-1:0]                lx_s;
    logic signed [ERR_W-1:0]                err_pol;
    logic signed [ERR_W-1:0]                extr;
    logic signed [ERR_W-1:0]                err_az;
    logic signed [ERR_W-1:0]                err_rad;
    logic [ERR_W-1:0]                       tol_ext;
    logic                                   pol_out;
    logic                                   az_out;
    logic                                   rad_out;
    logic signed [sgs_pkg::ANG_W:0]         inc_s;
    logic signed [sgs_pkg::ANG_W:0]         pol_sum;
    logic signed [sgs_pkg::ANG_W:0]         az_sum;
    logic signed [sgs_pkg::RAD_W+1:0]       rinc_s;
    logic signed [sgs_pkg::RAD_W+1:0]       rad_sum;
    logic signed [sgs_pkg::ANG_W-1:0]       polar_next;
    logic signed [sgs_pkg::ANG_W-1:0]       azim_next;
    logic [sgs_pkg::RAD_W-1:0]              radius_next;

    logic                                   cor_start;
    logic                                   cor_done;
    logic signed [sgs_pkg::ANG_W-1:0]       cor_angle;
    sgs_pkg::trig_t                         cor_result;
    logic                                   mul_start;
    logic                                   mul_done;
    logic signed [sgs_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [sgs_pkg::XY_W-1:0]        mul_b;
    logic signed [sgs_pkg::MUL_R_W-1:0]     mul_res;
    logic signed [sgs_pkg::MUL_R_W:0]       mul_res_ext;
    logic signed [sgs_pkg::MUL_R_W:0]       mul_res_neg;

    function automatic logic [ERR_W-1:0] mag(input logic signed [ERR_W-1:0] v);
        logic [ERR_W-1:0] m;
        if (v[ERR_W-1])
            m = ERR_W'(-v);
        else
            m = v;
        return m;
    endfunction

    function automatic logic signed [sgs_pkg::ANG_W-1:0] sat_angle(
        input logic signed [sgs_pkg::ANG_W:0] v
    );
        logic signed [sgs_pkg::ANG_W-1:0] r;
        if (v > sgs_pkg::ANG_MAX)
            r = sgs_pkg::ANG_MAX;
        else if (v < sgs_pkg::ANG_MIN)
            r = sgs_pkg::ANG_MIN;
        else
            r = v[sgs_pkg::ANG_W-1:0];
        return r;
    endfunction

    function automatic logic signed [sgs_pkg::OUT_W-1:0] sat_out(
        input logic signed [sgs_pkg::MUL_R_W:0] v
    );
        logic signed [sgs_pkg::OUT_W-1:0] r;
        if (v > sgs_pkg::OUT_MAX)
            r = sgs_pkg::OUT_MAX;
        else if (v < sgs_pkg::OUT_MIN)
            r = sgs_pkg::OUT_MIN;
        else
            r = v[sgs_pkg::OUT_W-1:0];
        return r;
    endfunction

    // Shared units
    sgs_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .angle  (cor_angle),
        .done   (cor_done),
        .result (cor_result)
    );

    sgs_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    // Pixel errors against the image centre and the right border distance
    always_comb
    begin
        y_sum   = {1'b0, ly_reg} + {1'b0, ry_reg};
        lx_s    = $signed({3'b0, lx_reg});
        err_pol = $signed({3'b0, y_sum[sgs_pkg::PIX_W:1]})
                  - $signed({4'b0, height_reg[sgs_pkg::PIX_W-1:1]});
        extr    = $signed({3'b0, width_reg}) - $signed({3'b0, rx_reg});
        err_az  = lx_s - extr;
        err_rad = lx_s - $signed({4'b0, width_reg[sgs_pkg::PIX_W-1:1]});
        tol_ext = {{(ERR_W - sgs_pkg::TOL_W){1'b0}}, half_tol_reg};
        pol_out = mag(err_pol) > tol_ext;
        az_out  = mag(err_az) > tol_ext;
        rad_out = mag(err_rad) > tol_ext;
    end

    // Saturating state updates
    always_comb
    begin
        inc_s   = $signed({5'b0, step_size_reg});
        rinc_s  = $signed({5'b0, step_size_reg, 1'b0});
        pol_sum = {polar_reg[sgs_pkg::ANG_W-1], polar_reg};
        az_sum  = {azim_reg[sgs_pkg::ANG_W-1], azim_reg};
        rad_sum = $signed({2'b0, radius_reg});
        if (pol_move_reg)
            pol_sum = pol_up_reg ? pol_sum + inc_s : pol_sum - inc_s;
        if (az_move_reg)
            az_sum = az_up_reg ? az_sum + inc_s : az_sum - inc_s;
        if (rad_move_reg)
            rad_sum = rad_up_reg ? rad_sum + rinc_s : rad_sum - rinc_s;
        polar_next = sat_angle(pol_sum);
        azim_next  = sat_angle(az_sum);
        if (rad_sum[sgs_pkg::RAD_W+1])
            radius_next = '0;
        else if (rad_sum > $signed({2'b0, sgs_pkg::RAD_MAX}))
            radius_next = sgs_pkg::RAD_MAX;
        else
            radius_next = rad_sum[sgs_pkg::RAD_W-1:0];
    end

    // Operand selection for the shared units
    always_comb
    begin
        cor_start = (state_reg == S_CPOL) || (state_reg == S_CAZ);
        cor_angle = (state_reg == S_CAZ) ? azim_reg : polar_reg;
        mul_start = (state_reg == S_M_T) || (state_reg == S_M_Y)
                    || (state_reg == S_M_X) || (state_reg == S_M_Z);
        case (state_reg)
            S_M_T:
            begin
                mul_a = $signed({3'b0, radius_reg});
                mul_b = pol_trig_reg.sin_q30;
            end
            S_M_Y:
            begin
                mul_a = $signed({3'b0, radius_reg});
                mul_b = pol_trig_reg.cos_q30;
            end
            S_M_X:
            begin
                mul_a = t_reg;
                mul_b = az_trig_reg.cos_q30;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = az_trig_reg.sin_q30;
            end
        endcase
        mul_res_ext = {mul_res[sgs_pkg::MUL_R_W-1], mul_res};
        mul_res_neg = -mul_res_ext;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= sgs_pkg::STEP_SIZE_RST;
            half_tol_reg  <= sgs_pkg::HALF_TOL_RST;
            width_reg     <= sgs_pkg::IMAGE_WIDTH_RST;
            height_reg    <= sgs_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sgs_pkg::REG_STEP_SIZE:    step_size_reg <= cfg_data[sgs_pkg::STEP_W-1:0];
                sgs_pkg::REG_HALF_TOL:     half_tol_reg  <= cfg_data[sgs_pkg::TOL_W-1:0];
                sgs_pkg::REG_IMAGE_WIDTH:  width_reg     <= cfg_data[sgs_pkg::PIX_W-1:0];
                sgs_pkg::REG_IMAGE_HEIGHT: height_reg    <= cfg_data[sgs_pkg::PIX_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Sequencer, gaze state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            polar_reg        <= sgs_pkg::ANGLE_RST;
            azim_reg         <= sgs_pkg::ANGLE_RST;
            radius_reg       <= sgs_pkg::RADIUS_RST;
            active_reg       <= 1'b0;
            stepped_reg      <= 1'b0;
            both_vis_reg     <= 1'b0;
            lx_reg           <= '0;
            ly_reg           <= '0;
            rx_reg           <= '0;
            ry_reg           <= '0;
            pol_move_reg     <= 1'b0;
            pol_up_reg       <= 1'b0;
            az_move_reg      <= 1'b0;
            az_up_reg        <= 1'b0;
            rad_move_reg     <= 1'b0;
            rad_up_reg       <= 1'b0;
            all_centred_reg  <= 1'b0;
            pol_trig_reg     <= '0;
            az_trig_reg      <= '0;
            t_reg            <= '0;
            fx_reg           <= '0;
            fy_reg           <= '0;
            fz_reg           <= '0;
            out_valid_reg    <= 1'b0;
            fixation_x_reg   <= '0;
            fixation_y_reg   <= '0;
            fixation_z_reg   <= '0;
            still_active_reg <= 1'b0;
            stepped_out_reg  <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new beat replaces it
            if (out_valid_reg && out_ready && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        both_vis_reg <= left_visible && right_visible;
                        lx_reg       <= left_x;
                        ly_reg       <= left_y;
                        rx_reg       <= right_x;
                        ry_reg       <= right_y;
                        active_reg   <= active_reg || start_req;
                        stepped_reg  <= active_reg || start_req;
                        if (active_reg || start_req)
                            state_reg <= S_ERR;
                        else
                            state_reg <= S_CPOL;
                    end
                end
                S_ERR:
                begin
                    pol_move_reg    <= both_vis_reg && pol_out;
                    pol_up_reg      <= !err_pol[ERR_W-1];
                    az_move_reg     <= both_vis_reg && az_out;
                    az_up_reg       <= !(err_az > 0);
                    rad_move_reg    <= both_vis_reg && !az_out && rad_out;
                    rad_up_reg      <= err_rad[ERR_W-1];
                    all_centred_reg <= both_vis_reg && !pol_out && !az_out && !rad_out;
                    state_reg       <= S_UPD;
                end
                S_UPD:
                begin
                    polar_reg  <= polar_next;
                    azim_reg   <= azim_next;
                    radius_reg <= radius_next;
                    active_reg <= !all_centred_reg;
                    state_reg  <= S_CPOL;
                end
                S_CPOL:
                begin
                    state_reg <= S_WPOL;
                end
                S_WPOL:
                begin
                    if (cor_done)
                    begin
                        pol_trig_reg <= cor_result;
                        state_reg    <= S_CAZ;
                    end
                end
                S_CAZ:
                begin
                    state_reg <= S_WAZ;
                end
                S_WAZ:
                begin
                    if (cor_done)
                    begin
                        az_trig_reg <= cor_result;
                        state_reg   <= S_M_T;
                    end
                end
                S_M_T:
                begin
                    state_reg <= S_W_T;
                end
                S_W_T:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= mul_res[sgs_pkg::MUL_A_W-1:0];
                        state_reg <= S_M_Y;
                    end
                end
                S_M_Y:
                begin
                    state_reg <= S_W_Y;
                end
                S_W_Y:
                begin
                    if (mul_done)
                    begin
                        fy_reg    <= sat_out(mul_res_neg);
                        state_reg <= S_M_X;
                    end
                end
                S_M_X:
                begin
                    state_reg <= S_W_X;
                end
                S_W_X:
                begin
                    if (mul_done)
                    begin
                        fx_reg    <= sat_out(mul_res_ext);
                        state_reg <= S_M_Z;
                    end
                end
                S_M_Z:
                begin
                    state_reg <= S_W_Z;
                end
                S_W_Z:
                begin
                    if (mul_done)
                    begin
                        fz_reg    <= sat_out(mul_res_ext);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        fixation_x_reg   <= fx_reg;
                        fixation_y_reg   <= fy_reg;
                        fixation_z_reg   <= fz_reg;
                        still_active_reg <= active_reg;
                        stepped_out_reg  <= stepped_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign fixation_x   = fixation_x_reg;
    assign fixation_y   = fixation_y_reg;
    assign fixation_z   = fixation_z_reg;
    assign still_active = still_active_reg;
    assign stepped      = stepped_out_reg;

    // The CORDIC only finishes while the sequencer waits on it
    a_cor_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == S_WPOL || state_reg == S_WAZ))
        else $error("CORDIC finished outside a wait state");

    // The multiplier only finishes while the sequencer waits on it
    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_W_T || state_reg == S_W_Y
                      || state_reg == S_W_X || state_reg == S_W_Z))
        else $error("multiplier finished outside a wait state");

    // An inactive tick skips the step and goes straight to the trig pass
    a_idle_tick_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !active_reg && !start_req) |=> (state_reg == S_CPOL))
        else $error("inactive tick entered the step stages");

    // A tick without a step never reports the servo as active
    a_no_step_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !stepped) |-> !still_active)
        else $error("still_active set on a tick without a step");

endmodule

`default_nettype wire

### rtl/sgs_cordic.sv
`default_nettype none

module sgs_cordic #(
    parameter int ITERATIONS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [sgs_pkg::ANG_W-1:0] angle,
    output logic                                  done,
    output sgs_pkg::trig_t                        result
);

    localparam int ITER_W = $clog2(ITERATIONS);

    typedef enum logic [2:0] {
        C_IDLE,
        C_RED0,
        C_RED1,
        C_FOLD,
        C_ITER,
        C_SIGN,
        C_DONE
    } cor_state_t;

    cor_state_t                            state_reg;
    logic signed [sgs_pkg::Z_W-1:0]        z_reg;
    logic signed [sgs_pkg::XY_W-1:0]       x_reg;
    logic signed [sgs_pkg::XY_W-1:0]       y_reg;
    logic                                  neg_reg;
    logic [ITER_W-1:0]                     iter_reg;

    logic signed [sgs_pkg::XY_W-1:0]       dx;
    logic signed [sgs_pkg::XY_W-1:0]       dy;
    logic signed [sgs_pkg::Z_W-1:0]        atan_step;
    logic signed [sgs_pkg::Z_W-1:0]        z_wrapped;

    // Fold the angle once into [-pi, pi]
    function automatic logic signed [sgs_pkg::Z_W-1:0] wrap_pass(
        input logic signed [sgs_pkg::Z_W-1:0] v
    );
        logic signed [sgs_pkg::Z_W-1:0] w;
        w = v;
        if (w > sgs_pkg::PI_Q16)
            w = w - sgs_pkg::TWO_PI_Q16;
        if (w < sgs_pkg::NEG_PI_Q16)
            w = w + sgs_pkg::TWO_PI_Q16;
        return w;
    endfunction

    // Shifted cross terms and table angle for this iteration
    always_comb
    begin
        dx        = y_reg >>> iter_reg;
        dy        = x_reg >>> iter_reg;
        atan_step = $signed({5'b0, sgs_pkg::atan_q16(sgs_pkg::ATAN_IDX_W'(iter_reg))});
        z_wrapped = wrap_pass(z_reg);
    end

    // Sequence reduction, rotations and sign fix-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            z_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            neg_reg   <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        z_reg     <= {angle[sgs_pkg::ANG_W-1], angle};
                        x_reg     <= sgs_pkg::CORDIC_GAIN_Q30;
                        y_reg     <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= C_RED0;
                    end
                end
                C_RED0:
                begin
                    z_reg     <= z_wrapped;
                    state_reg <= C_RED1;
                end
                C_RED1:
                begin
                    z_reg     <= z_wrapped;
                    state_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    // Bring the angle into the right half plane
                    if (z_reg > sgs_pkg::HALF_PI_Q16)
                    begin
                        z_reg   <= z_reg - sgs_pkg::PI_Q16;
                        neg_reg <= 1'b1;
                    end
                    else if (z_reg < sgs_pkg::NEG_HALF_PI_Q16)
                    begin
                        z_reg   <= z_reg + sgs_pkg::PI_Q16;
                        neg_reg <= 1'b1;
                    end
                    iter_reg  <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (!z_reg[sgs_pkg::Z_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_step;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_step;
                    end
                    if (iter_reg == ITER_W'(ITERATIONS - 1))
                        state_reg <= C_SIGN;
                    else
                        iter_reg <= iter_reg + 1'b1;
                end
                C_SIGN:
                begin
                    if (neg_reg)
                    begin
                        x_reg <= -x_reg;
                        y_reg <= -y_reg;
                    end
                    state_reg <= C_DONE;
                end
                C_DONE:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done           = (state_reg == C_DONE);
    assign result.sin_q30 = y_reg;
    assign result.cos_q30 = x_reg;

endmodule

`default_nettype wire

### rtl/sgs_mul.sv
`default_nettype none

module sgs_mul (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [sgs_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [sgs_pkg::XY_W-1:0]     b,
    output logic                                     done,
    output logic signed [sgs_pkg::MUL_R_W-1:0]       result
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_DONE
    } mul_state_t;

    mul_state_t                               state_reg;
    logic signed [sgs_pkg::MUL_A_W-1:0]       a_reg;
    logic signed [sgs_pkg::XY_W-1:0]          b_reg;
    logic signed [sgs_pkg::MUL_P_W-1:0]       acc_reg;

    logic signed [sgs_pkg::MUL_SPLIT:0]       b_part;
    logic signed [sgs_pkg::MUL_PP_W-1:0]      pp;
    logic signed [sgs_pkg::MUL_P_W-1:0]       pp_ext;

    // One narrow product a cycle: low half of B unsigned, then high half signed
    always_comb
    begin
        if (state_reg == M_LO)
            b_part = $signed({1'b0, b_reg[sgs_pkg::MUL_SPLIT-1:0]});
        else
            b_part = $signed({b_reg[sgs_pkg::XY_W-1],
                              b_reg[sgs_pkg::XY_W-1:sgs_pkg::MUL_SPLIT]});
        pp     = a_reg * b_part;
        pp_ext = {{(sgs_pkg::MUL_P_W - sgs_pkg::MUL_PP_W){pp[sgs_pkg::MUL_PP_W-1]}}, pp};
    end

    // Accumulate the two partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        b_reg     <= b;
                        state_reg <= M_LO;
                    end
                end
                M_LO:
                begin
                    acc_reg   <= pp_ext;
                    state_reg <= M_HI;
                end
                M_HI:
                begin
                    acc_reg   <= acc_reg + (pp_ext <<< sgs_pkg::MUL_SPLIT);
                    state_reg <= M_DONE;
                end
                M_DONE:
                begin
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    // Floor shift by 30 is the top slice of the product
    assign done   = (state_reg == M_DONE);
    assign result = acc_reg[sgs_pkg::MUL_P_W-1:sgs_pkg::MUL_SHIFT];

endmodule

`default_nettype wire

### tb/gaze_point_checker.sv
`timescale 1ns / 1ps

module gaze_point_checker #(
    parameter int ROTATIONS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic                               start_req,
    input  wire logic                               left_visible,
    input  wire logic [sgs_pkg::PIX_W-1:0]          left_x,
    input  wire logic [sgs_pkg::PIX_W-1:0]          left_y,
    input  wire logic                               right_visible,
    input  wire logic [sgs_pkg::PIX_W-1:0]          right_x,
    input  wire logic [sgs_pkg::PIX_W-1:0]          right_y,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [sgs_pkg::OUT_W-1:0]   fixation_x,
    input  wire logic signed [sgs_pkg::OUT_W-1:0]   fixation_y,
    input  wire logic signed [sgs_pkg::OUT_W-1:0]   fixation_z,
    input  wire logic                               still_active,
    input  wire logic                               stepped,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [sgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sgs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                      mismatch_count,
    output int                                      ticks_pending
);

    // Q16 angle constants and Q30 start vector
    localparam int PI_Q        = 205887;
    localparam int TWO_PI_Q    = 411775;
    localparam int HALF_PI_Q   = 102944;
    localparam longint START_X = 652032874;

    // Register limits of the gaze state and of the result fields
    localparam longint ANGLE_TOP    = 524287;
    localparam longint ANGLE_BOTTOM = -524288;
    localparam longint RADIUS_TOP   = 1048575;
    localparam longint FIX_TOP      = 1048575;
    localparam longint FIX_BOTTOM   = -1048576;
    localparam int TABLE_DEPTH      = 24;

    typedef struct packed {
        logic signed [sgs_pkg::OUT_W-1:0] fx;
        logic signed [sgs_pkg::OUT_W-1:0] fy;
        logic signed [sgs_pkg::OUT_W-1:0] fz;
        logic                             active;
        logic                             moved;
    } fixation_t;

    int arctan_q16 [TABLE_DEPTH] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    // Predicted gaze state and register copies
    int polar_q;
    int azimuth_q;
    int radius_q;
    bit servo_on;
    int step_cfg;
    int tol_cfg;
    int width_cfg;
    int height_cfg;

    fixation_t fixation_due [$];
    fixation_t oldest;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Sine and cosine in Q30 of a Q16 angle by rotation-mode CORDIC
    function automatic void sin_cos_q30(input int angle, output longint s, output longint c);
        int z;
        bit flip;
        int n;
        longint x;
        longint y;
        longint nx;
        z = angle;
        flip = 1'b0;
        x = START_X;
        y = 0;
        repeat (2)
        begin
            if (z > PI_Q)
                z -= TWO_PI_Q;
            if (z < -PI_Q)
                z += TWO_PI_Q;
        end
        // Fold into the right half-plane and negate afterwards
        if (z > HALF_PI_Q)
        begin
            z -= PI_Q;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q)
        begin
            z += PI_Q;
            flip = 1'b1;
        end
        n = (ROTATIONS > TABLE_DEPTH) ? TABLE_DEPTH : ROTATIONS;
        for (int i = 0; i < n; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_q16[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_q16[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // Advance the gaze state by one tick and give the fixation point it yields
    function automatic fixation_t next_fixation(input logic go, input logic lv, input logic rv,
                                                input int lx, input int ly,
                                                input int rx, input int ry);
        fixation_t r;
        bit ran;
        bit pol_ok;
        bit az_ok;
        bit rad_ok;
        int ym;
        int border;
        longint sp;
        longint cp;
        longint sa;
        longint ca;
        longint t;
        if (go)
            servo_on = 1'b1;
        ran = servo_on;
        if (servo_on)
        begin
            pol_ok = 1'b0;
            az_ok = 1'b0;
            rad_ok = 1'b0;
            if (lv && rv)
            begin
                ym = (ly + ry) >> 1;
                border = width_cfg - rx;
                if (mag(ym - (height_cfg >> 1)) > tol_cfg)
                    polar_q = int'(clip(longint'(polar_q)
                              + ((ym < (height_cfg >> 1)) ? -step_cfg : step_cfg),
                              ANGLE_BOTTOM, ANGLE_TOP));
                else
                    pol_ok = 1'b1;
                if (mag(lx - border) > tol_cfg)
                    azimuth_q = int'(clip(longint'(azimuth_q)
                                + ((lx > border) ? -step_cfg : step_cfg),
                                ANGLE_BOTTOM, ANGLE_TOP));
                else
                    az_ok = 1'b1;
                // Range only moves once the azimuth has settled
                if (az_ok)
                begin
                    if (mag(lx - (width_cfg >> 1)) > tol_cfg)
                        radius_q = int'(clip(longint'(radius_q)
                                   + ((lx < (width_cfg >> 1)) ? 2 * step_cfg : -2 * step_cfg),
                                   0, RADIUS_TOP));
                    else
                        rad_ok = 1'b1;
                end
            end
            servo_on = !(pol_ok && az_ok && rad_ok);
        end
        sin_cos_q30(polar_q, sp, cp);
        sin_cos_q30(azimuth_q, sa, ca);
        t = (longint'(radius_q) * sp) >>> 30;
        r.fx = sgs_pkg::OUT_W'(clip((t * ca) >>> 30, FIX_BOTTOM, FIX_TOP));
        r.fz = sgs_pkg::OUT_W'(clip((t * sa) >>> 30, FIX_BOTTOM, FIX_TOP));
        r.fy = sgs_pkg::OUT_W'(clip(-((longint'(radius_q) * cp) >>> 30),
                                    FIX_BOTTOM, FIX_TOP));
        r.active = servo_on;
        r.moved = ran;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Track register writes, check output beats, predict on input beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polar_q = 102943;
            azimuth_q = 102943;
            radius_q = 52429;
            servo_on = 1'b0;
            step_cfg = 655;
            tol_cfg = 1;
            width_cfg = 640;
            height_cfg = 480;
            fixation_due.delete();
            mismatch_count = 0;
            ticks_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (sgs_pkg::cfg_reg_t'(cfg_index))
                    sgs_pkg::REG_STEP_SIZE:    step_cfg = int'(cfg_data);
                    sgs_pkg::REG_HALF_TOL:     tol_cfg = int'(cfg_data[sgs_pkg::TOL_W-1:0]);
                    sgs_pkg::REG_IMAGE_WIDTH:  width_cfg = int'(cfg_data[sgs_pkg::PIX_W-1:0]);
                    sgs_pkg::REG_IMAGE_HEIGHT: height_cfg = int'(cfg_data[sgs_pkg::PIX_W-1:0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (fixation_due.size() == 0)
                    log_mismatch($sformatf("output beat with nothing expected (x %0d y %0d z %0d)",
                                           fixation_x, fixation_y, fixation_z));
                else
                begin
                    oldest = fixation_due.pop_front();
                    if (fixation_x !== oldest.fx)
                        log_mismatch($sformatf("fixation_x got %0d, want %0d",
                                               fixation_x, oldest.fx));
                    if (fixation_y !== oldest.fy)
                        log_mismatch($sformatf("fixation_y got %0d, want %0d",
                                               fixation_y, oldest.fy));
                    if (fixation_z !== oldest.fz)
                        log_mismatch($sformatf("fixation_z got %0d, want %0d",
                                               fixation_z, oldest.fz));
                    if (still_active !== oldest.active)
                        log_mismatch($sformatf("still_active got %b, want %b",
                                               still_active, oldest.active));
                    if (stepped !== oldest.moved)
                        log_mismatch($sformatf("stepped got %b, want %b",
                                               stepped, oldest.moved));
                end
            end
            if (in_valid && in_ready)
                fixation_due.push_back(next_fixation(start_req, left_visible, right_visible,
                                                     int'(left_x), int'(left_y),
                                                     int'(right_x), int'(right_y)));
            ticks_pending <= fixation_due.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ROT = 16;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic                             start_req;
    logic                             left_visible;
    logic [sgs_pkg::PIX_W-1:0]        left_x;
    logic [sgs_pkg::PIX_W-1:0]        left_y;
    logic                             right_visible;
    logic [sgs_pkg::PIX_W-1:0]        right_x;
    logic [sgs_pkg::PIX_W-1:0]        right_y;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [sgs_pkg::OUT_W-1:0] fixation_x;
    logic signed [sgs_pkg::OUT_W-1:0] fixation_y;
    logic signed [sgs_pkg::OUT_W-1:0] fixation_z;
    logic                             still_active;
    logic                             stepped;
    logic                             cfg_valid;
    logic                             cfg_ready;
    sgs_pkg::cfg_reg_t                cfg_index;
    logic [sgs_pkg::CFG_DATA_W-1:0]   cfg_data;
    int                               mismatch_count;
    int                               ticks_pending;

    // Current register values, used only to aim the stimulus
    int cur_w;
    int cur_h;
    int cur_tol;
    bit idle_off = 1'b0;
    bit hold_request = 1'b0;

    stereo_gaze_servo_step #(
        .CORDIC_ITERATIONS (ROT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .left_visible  (left_visible),
        .left_x        (left_x),
        .left_y        (left_y),
        .right_visible (right_visible),
        .right_x       (right_x),
        .right_y       (right_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fixation_x    (fixation_x),
        .fixation_y    (fixation_y),
        .fixation_z    (fixation_z),
        .still_active  (still_active),
        .stepped       (stepped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gaze_point_checker #(
        .ROTATIONS (ROT)
    ) gaze_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_req      (start_req),
        .left_visible   (left_visible),
        .left_x         (left_x),
        .left_y         (left_y),
        .right_visible  (right_visible),
        .right_x        (right_x),
        .right_y        (right_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fixation_x     (fixation_x),
        .fixation_y     (fixation_y),
        .fixation_z     (fixation_z),
        .still_active   (still_active),
        .stepped        (stepped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .ticks_pending  (ticks_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request, none at the end
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!idle_off && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge clk);
            end
        end
    end

    function automatic logic [sgs_pkg::PIX_W-1:0] pix(input int v);
        return (v < 0) ? '0 : ((v > 4095) ? '1 : sgs_pkg::PIX_W'(v));
    endfunction

    function automatic int jitter(input int b);
        return int'($urandom_range(0, 2 * b)) - b;
    endfunction

    // Offer one tick, possibly after a gap, and hold it until the beat is taken
    task automatic offer_servo_tick(input logic st, input logic lv,
                                    input logic [sgs_pkg::PIX_W-1:0] lx,
                                    input logic [sgs_pkg::PIX_W-1:0] ly,
                                    input logic rv,
                                    input logic [sgs_pkg::PIX_W-1:0] rx,
                                    input logic [sgs_pkg::PIX_W-1:0] ry);
        if (!idle_off && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_req     <= st;
        left_visible  <= lv;
        left_x        <= lx;
        left_y        <= ly;
        right_visible <= rv;
        right_x       <= rx;
        right_y       <= ry;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Mostly blobs near the centre of the current image, some noise and lost blobs
    task automatic offer_random_tick();
        int kind;
        int band;
        logic st;
        logic lv;
        logic rv;
        logic [sgs_pkg::PIX_W-1:0] lx;
        kind = $urandom_range(0, 99);
        st = ($urandom_range(0, 5) == 0);
        if (kind < 12)
            offer_servo_tick(st, 1'($urandom),
                             sgs_pkg::PIX_W'($urandom), sgs_pkg::PIX_W'($urandom),
                             1'($urandom),
                             sgs_pkg::PIX_W'($urandom), sgs_pkg::PIX_W'($urandom));
        else if (kind < 24)
        begin
            lv = 1'($urandom);
            rv = lv ? 1'b0 : 1'($urandom);
            offer_servo_tick(st, lv, sgs_pkg::PIX_W'($urandom), sgs_pkg::PIX_W'($urandom),
                             rv, sgs_pkg::PIX_W'($urandom), sgs_pkg::PIX_W'($urandom));
        end
        else
        begin
            band = (kind < 62) ? cur_tol + 3 : cur_tol + 60;
            lx = pix(cur_w / 2 + jitter(band));
            offer_servo_tick(st, 1'b1, lx, pix(cur_h / 2 + jitter(band)),
                             1'b1, pix(cur_w - int'(lx) + jitter(band)),
                             pix(cur_h / 2 + jitter(band)));
        end
    endtask

    task automatic put_register(input sgs_pkg::cfg_reg_t idx,
                                input logic [sgs_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Write all four registers, with junk in the unused upper bits
    task automatic write_registers(input logic [sgs_pkg::STEP_W-1:0] step,
                                   input logic [sgs_pkg::TOL_W-1:0] tol,
                                   input logic [sgs_pkg::PIX_W-1:0] w,
                                   input logic [sgs_pkg::PIX_W-1:0] h);
        logic [sgs_pkg::CFG_DATA_W-1:0] junk;
        junk = sgs_pkg::CFG_DATA_W'($urandom);
        put_register(sgs_pkg::REG_STEP_SIZE, step);
        put_register(sgs_pkg::REG_HALF_TOL, {junk[15:8], tol});
        put_register(sgs_pkg::REG_IMAGE_WIDTH, {junk[3:0], w});
        put_register(sgs_pkg::REG_IMAGE_HEIGHT, {junk[7:4], h});
        cfg_valid <= 1'b0;
        cur_tol = int'(tol);
        cur_w = int'(w);
        cur_h = int'(h);
    endtask

    // Drop valid and wait until every predicted fixation has been drained
    task automatic drain_fixations();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ticks_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        start_req     <= 1'b0;
        left_visible  <= 1'b0;
        left_x        <= '0;
        left_y        <= '0;
        right_visible <= 1'b0;
        right_x       <= '0;
        right_y       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= sgs_pkg::REG_STEP_SIZE;
        cfg_data      <= '0;
        cur_w = 640;
        cur_h = 480;
        cur_tol = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset register values
        offer_servo_tick(1'b0, 1'b1, 12'd320, 12'd240, 1'b1, 12'd320, 12'd240);
        offer_servo_tick(1'b0, 1'b0, 12'd0, 12'd0, 1'b0, 12'd0, 12'd0);
        offer_servo_tick(1'b0, 1'b1, 12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095);
        // Start with the blob lost, then seen by one eye only
        offer_servo_tick(1'b1, 1'b0, 12'd320, 12'd240, 1'b0, 12'd320, 12'd240);
        offer_servo_tick(1'b0, 1'b1, 12'd10, 12'd20, 1'b0, 12'd30, 12'd40);
        offer_servo_tick(1'b0, 1'b0, 12'd4000, 12'd4001, 1'b1, 12'd4002, 12'd4003);
        // Both angles move at the field extremes
        offer_servo_tick(1'b0, 1'b1, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0);
        offer_servo_tick(1'b0, 1'b1, 12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095);
        // Azimuth settled, range moves out then in
        offer_servo_tick(1'b0, 1'b1, 12'd100, 12'd240, 1'b1, 12'd540, 12'd240);
        offer_servo_tick(1'b0, 1'b1, 12'd500, 12'd241, 1'b1, 12'd140, 12'd240);
        // Polar and range errors on the dead-band edge, azimuth centred: servo drops out
        offer_servo_tick(1'b0, 1'b1, 12'd321, 12'd241, 1'b1, 12'd319, 12'd242);
        offer_servo_tick(1'b0, 1'b1, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0);
        // Just outside the dead band, then centred, far off, and just outside again
        offer_servo_tick(1'b1, 1'b1, 12'd322, 12'd242, 1'b1, 12'd318, 12'd242);
        offer_servo_tick(1'b1, 1'b1, 12'd320, 12'd240, 1'b1, 12'd320, 12'd240);
        offer_servo_tick(1'b1, 1'b1, 12'd3000, 12'd1, 1'b1, 12'd1, 12'd4094);
        offer_servo_tick(1'b1, 1'b1, 12'd318, 12'd239, 1'b1, 12'd322, 12'd240);

        for (int phase = 0; phase < 9; phase++)
        begin
            drain_fixations();
            case (phase)
                0: write_registers(16'hFFFF, 8'd0, 12'd4095, 12'd4095);
                1: write_registers(16'd0, 8'd255, 12'd2, 12'd2);
                2: write_registers(16'd655, 8'd1, 12'd640, 12'd480);
                3: write_registers(sgs_pkg::STEP_W'($urandom), 8'd0, 12'd0, 12'd0);
                8: write_registers(16'd1200, 8'd3, 12'd320, 12'd240);
                default: write_registers(sgs_pkg::STEP_W'($urandom_range(0, 4000)),
                                         sgs_pkg::TOL_W'($urandom_range(0, 12)),
                                         sgs_pkg::PIX_W'($urandom_range(2, 4095)),
                                         sgs_pkg::PIX_W'($urandom_range(2, 4095)));
            endcase
            if (phase == 0)
            begin
                // Drive both angles and then the range into their limits
                repeat (17) offer_servo_tick(1'b1, 1'b1, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0);
                repeat (17) offer_servo_tick(1'b1, 1'b1, 12'd4095, 12'd4095,
                                             1'b1, 12'd4095, 12'd4095);
                repeat (9) offer_servo_tick(1'b1, 1'b1, 12'd0, 12'd2047,
                                            1'b1, 12'd4095, 12'd2047);
                repeat (9) offer_servo_tick(1'b1, 1'b1, 12'd4095, 12'd2047,
                                            1'b1, 12'd0, 12'd2047);
            end
            if (phase == 2)
                hold_request = 1'b1;
            if (phase == 8)
                idle_off = 1'b1;
            repeat ((phase == 2) ? 150 : 80) offer_random_tick();
        end

        drain_fixations();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/sgs_pkg.sv
rtl/sgs_cordic.sv
rtl/sgs_mul.sv
rtl/stereo_gaze_servo_step.sv
tb/gaze_point_checker.sv
tb/tb.sv
